/* sv/trs_to_instance_matrix_assert.svh */
// Assertion macros shared by the checker of the pose-to-matrix composer.
// Holds no logic; the checker includes this header by its bare file name.
`ifndef TRS_TO_INSTANCE_MATRIX_ASSERT_SVH
`define TRS_TO_INSTANCE_MATRIX_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define TRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define TRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/trs_pkg.sv */
// Package of the pose-to-matrix composer: widths, payload types and the
// fixed-point helpers. Depends on nothing; every other module uses it.
`default_nettype none

package trs_pkg;

    localparam int QW     = 16;          // quaternion and scale width
    localparam int ELEMW  = 32;          // Q16.16 element width
    localparam int PRODW  = 2 * QW + 1;  // 2*qa*qb
    localparam int ENTW   = PRODW + 1;   // rotation entry, Q.28
    localparam int MULW   = ENTW + QW;   // entry times scale, Q.36
    localparam int FRAC_Q = 28;
    localparam int RSH    = 20;          // Q.36 down to Q.16
    localparam int SATW   = (MULW - RSH + 1 > ELEMW) ? (MULW - RSH + 2) : (ELEMW + 1);
    localparam int NENT   = 9;

    // Product slots.
    localparam int P_XX = 0;
    localparam int P_XY = 1;
    localparam int P_XZ = 2;
    localparam int P_YY = 3;
    localparam int P_YZ = 4;
    localparam int P_ZZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    // Column codes.
    localparam logic [1:0] COL_X     = 2'd0;
    localparam logic [1:0] COL_Y     = 2'd1;
    localparam logic [1:0] COL_Z     = 2'd2;
    localparam logic [1:0] COL_TRANS = 2'd3;

    typedef logic signed [QW-1:0]    t_q;
    typedef logic signed [PRODW-1:0] t_prod;
    typedef logic signed [ENTW-1:0]  t_entry;
    typedef logic signed [MULW-1:0]  t_mul;
    typedef logic signed [ELEMW-1:0] t_elem;

    typedef t_prod  [NENT-1:0] t_prods;
    typedef t_entry [NENT-1:0] t_entries;
    typedef t_mul   [NENT-1:0] t_muls;
    typedef t_elem  [NENT-1:0] t_elems;

    // Everything of a pose that rides alongside the arithmetic.
    typedef struct packed {
        t_elem pos_x;
        t_elem pos_y;
        t_elem pos_z;
        t_q    scale_x;
        t_q    scale_y;
        t_q    scale_z;
        logic  fin;
    } t_side;

    localparam t_entry ONE_Q28 = ENTW'(1) << FRAC_Q;
    localparam logic signed [MULW:0] RND = (MULW + 1)'(1) << (RSH - 1);
    localparam logic signed [SATW-1:0] SAT_HI = SATW'(32'sh7FFF_FFFF);
    localparam logic signed [SATW-1:0] SAT_LO = SATW'(32'sh8000_0000);

    // Twice the product of two Q1.14 values, exact in Q.28.
    function automatic t_prod qprod2(input t_q a, input t_q b);
        logic signed [2*QW-1:0] m;
        m = a * b;
        return {m, 1'b0};
    endfunction

    function automatic t_entry ext(input t_prod p);
        return {p[PRODW-1], p};
    endfunction

    function automatic t_entry ent_add(input t_prod a, input t_prod b);
        return ext(a) + ext(b);
    endfunction

    function automatic t_entry ent_sub(input t_prod a, input t_prod b);
        return ext(a) - ext(b);
    endfunction

    function automatic t_entry ent_one_minus(input t_prod a, input t_prod b);
        return ONE_Q28 - (ext(a) + ext(b));
    endfunction

    function automatic t_mul scale_mul(input t_entry e, input t_q s);
        return e * s;
    endfunction

    // Round half up to Q16.16, then clamp to the 32-bit range.
    function automatic t_elem round_sat(input t_mul m);
        logic signed [MULW:0]     p;
        logic signed [MULW-RSH:0] r;
        logic signed [SATW-1:0]   w;
        p = (MULW + 1)'(m) + RND;
        r = p[MULW:RSH];
        w = SATW'(r);
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return w[ELEMW-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/trs_rot.sv */
// Rotation front end: quaternion products, then the nine rotation entries.
// Two register stages with valid/ready flow control; uses trs_pkg.
`default_nettype none

module trs_rot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  trs_pkg::t_q        i_qx,
    input  trs_pkg::t_q        i_qy,
    input  trs_pkg::t_q        i_qz,
    input  trs_pkg::t_q        i_qw,
    input  trs_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output trs_pkg::t_entries  o_ent,
    output trs_pkg::t_side     o_side
);

    logic              r_v1;
    trs_pkg::t_prods   r_prod;
    trs_pkg::t_prods   n_prod;
    trs_pkg::t_side    r_side1;
    logic              r_v2;
    trs_pkg::t_entries r_ent;
    trs_pkg::t_entries n_ent;
    trs_pkg::t_side    r_side2;
    logic              w_adv1;
    logic              w_adv2;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    always_comb begin
        n_prod[trs_pkg::P_XX] = trs_pkg::qprod2(i_qx, i_qx);
        n_prod[trs_pkg::P_XY] = trs_pkg::qprod2(i_qx, i_qy);
        n_prod[trs_pkg::P_XZ] = trs_pkg::qprod2(i_qx, i_qz);
        n_prod[trs_pkg::P_YY] = trs_pkg::qprod2(i_qy, i_qy);
        n_prod[trs_pkg::P_YZ] = trs_pkg::qprod2(i_qy, i_qz);
        n_prod[trs_pkg::P_ZZ] = trs_pkg::qprod2(i_qz, i_qz);
        n_prod[trs_pkg::P_WX] = trs_pkg::qprod2(i_qw, i_qx);
        n_prod[trs_pkg::P_WY] = trs_pkg::qprod2(i_qw, i_qy);
        n_prod[trs_pkg::P_WZ] = trs_pkg::qprod2(i_qw, i_qz);
    end

    // Entries are stored column by column, three rows each.
    always_comb begin
        n_ent[0] = trs_pkg::ent_one_minus(r_prod[trs_pkg::P_YY], r_prod[trs_pkg::P_ZZ]);
        n_ent[1] = trs_pkg::ent_add(r_prod[trs_pkg::P_XY], r_prod[trs_pkg::P_WZ]);
        n_ent[2] = trs_pkg::ent_sub(r_prod[trs_pkg::P_XZ], r_prod[trs_pkg::P_WY]);
        n_ent[3] = trs_pkg::ent_sub(r_prod[trs_pkg::P_XY], r_prod[trs_pkg::P_WZ]);
        n_ent[4] = trs_pkg::ent_one_minus(r_prod[trs_pkg::P_XX], r_prod[trs_pkg::P_ZZ]);
        n_ent[5] = trs_pkg::ent_add(r_prod[trs_pkg::P_YZ], r_prod[trs_pkg::P_WX]);
        n_ent[6] = trs_pkg::ent_add(r_prod[trs_pkg::P_XZ], r_prod[trs_pkg::P_WY]);
        n_ent[7] = trs_pkg::ent_sub(r_prod[trs_pkg::P_YZ], r_prod[trs_pkg::P_WX]);
        n_ent[8] = trs_pkg::ent_one_minus(r_prod[trs_pkg::P_XX], r_prod[trs_pkg::P_YY]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_prod  <= n_prod;
            r_side1 <= i_side;
        end
        if (w_adv2 && r_v1) begin
            r_ent   <= n_ent;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_ent   = r_ent;
    assign o_side  = r_side2;

endmodule

`default_nettype wire

/* sv/trs_scl.sv */
// Scaling back end: each entry times its column scale, then rounding and
// saturation to Q16.16. Two register stages with valid/ready; uses trs_pkg.
`default_nettype none

module trs_scl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  trs_pkg::t_entries  i_ent,
    input  trs_pkg::t_side     i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output trs_pkg::t_elems    o_elem,
    output trs_pkg::t_side     o_side
);

    logic            r_v3;
    trs_pkg::t_muls  r_mul;
    trs_pkg::t_muls  n_mul;
    trs_pkg::t_side  r_side3;
    logic            r_v4;
    trs_pkg::t_elems r_elem;
    trs_pkg::t_elems n_elem;
    trs_pkg::t_side  r_side4;
    trs_pkg::t_q     w_scale [3];
    logic            w_adv3;
    logic            w_adv4;

    assign w_adv4  = !r_v4 || i_ready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign o_ready = w_adv3;

    assign w_scale[0] = i_side.scale_x;
    assign w_scale[1] = i_side.scale_y;
    assign w_scale[2] = i_side.scale_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                n_mul[c*3+r] = trs_pkg::scale_mul(i_ent[c*3+r], w_scale[c]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < trs_pkg::NENT; k++) begin
            n_elem[k] = trs_pkg::round_sat(r_mul[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv3) begin
                r_v3 <= i_valid;
            end
            if (w_adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && i_valid) begin
            r_mul   <= n_mul;
            r_side3 <= i_side;
        end
        if (w_adv4 && r_v3) begin
            r_elem  <= n_elem;
            r_side4 <= r_side3;
        end
    end

    assign o_valid = r_v4;
    assign o_elem  = r_elem;
    assign o_side  = r_side4;

endmodule

`default_nettype wire

/* sv/trs_ser.sv */
// Column serialiser: holds one finished matrix and hands it out as four
// column transactions. Uses trs_pkg for the column codes and types.
`default_nettype none

module trs_ser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  trs_pkg::t_elems   i_elem,
    input  trs_pkg::t_side    i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_column_index,
    output trs_pkg::t_elem    o_elem_x,
    output trs_pkg::t_elem    o_elem_y,
    output trs_pkg::t_elem    o_elem_z,
    output logic              o_last_column,
    output logic              o_last_of_batch
);

    logic            r_valid;
    logic [1:0]      r_col;
    trs_pkg::t_elems r_elem;
    trs_pkg::t_side  r_side;
    logic            w_take;
    logic            w_fire;
    logic            w_last;

    assign w_last  = (r_col == trs_pkg::COL_TRANS);
    assign w_fire  = r_valid && i_ready;
    // A new matrix is taken in the cycle its predecessor's last column leaves.
    assign w_take  = !r_valid || (i_ready && w_last);
    assign o_ready = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= trs_pkg::COL_X;
        end else if (w_take && i_valid) begin
            r_valid <= 1'b1;
            r_col   <= trs_pkg::COL_X;
        end else if (w_fire) begin
            r_col <= r_col + 2'd1;
            if (w_last) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) begin
            r_elem <= i_elem;
            r_side <= i_side;
        end
    end

    always_comb begin
        case (r_col)
            trs_pkg::COL_X: begin
                o_elem_x = r_elem[0];
                o_elem_y = r_elem[1];
                o_elem_z = r_elem[2];
            end
            trs_pkg::COL_Y: begin
                o_elem_x = r_elem[3];
                o_elem_y = r_elem[4];
                o_elem_z = r_elem[5];
            end
            trs_pkg::COL_Z: begin
                o_elem_x = r_elem[6];
                o_elem_y = r_elem[7];
                o_elem_z = r_elem[8];
            end
            default: begin
                o_elem_x = r_side.pos_x;
                o_elem_y = r_side.pos_y;
                o_elem_z = r_side.pos_z;
            end
        endcase
    end

    assign o_valid         = r_valid;
    assign o_column_index  = r_col;
    assign o_last_column   = w_last;
    assign o_last_of_batch = w_last && r_side.fin;

endmodule

`default_nettype wire

/* sv/trs_to_instance_matrix.sv */
// Top level of the instance pose to 4x4 matrix composer.
// Instantiates trs_rot, trs_scl and trs_ser; uses trs_pkg.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------------------
//  pose     | in        | i_in_valid / o_in_ready    | position, quaternion, scales, final
//  column   | out       | o_out_valid / i_out_ready  | index, x, y, z, last flags
//
// Each pose transaction yields four column transactions, so when the result side never
// stalls, the single result port sets the pace at which poses are taken.
// The edge that accepts a pose loads the first rotation stage; the pose then moves on
// through the second rotation stage, the two scaling stages and the serialiser register,
// from which its first column appears.
// Reset is synchronous and clears only the valid flags and the column counter.
// A stall on the result side holds the current column and fills the stages behind it;
// up to five poses can be in flight, and nothing is lost or repeated.
`default_nettype none

module trs_to_instance_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_scale_x,
    input  logic signed [15:0] i_scale_y,
    input  logic signed [15:0] i_scale_z,
    input  logic               i_final_instance,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_column_index,
    output logic signed [31:0] o_elem_x,
    output logic signed [31:0] o_elem_y,
    output logic signed [31:0] o_elem_z,
    output logic               o_last_column,
    output logic               o_last_of_batch
);

    // The side data (position, scales, batch flag) travels with the arithmetic so
    // that every stage holds a complete pose.
    trs_pkg::t_side    w_side_in;
    trs_pkg::t_side    w_side_rot;
    trs_pkg::t_side    w_side_scl;
    trs_pkg::t_entries w_ent;
    trs_pkg::t_elems   w_elem;
    logic              w_rot_valid;
    logic              w_rot_ready;
    logic              w_scl_valid;
    logic              w_scl_ready;

    assign w_side_in.pos_x   = i_pos_x;
    assign w_side_in.pos_y   = i_pos_y;
    assign w_side_in.pos_z   = i_pos_z;
    assign w_side_in.scale_x = i_scale_x;
    assign w_side_in.scale_y = i_scale_y;
    assign w_side_in.scale_z = i_scale_z;
    assign w_side_in.fin     = i_final_instance;

    // Quaternion products, then the nine unscaled rotation entries in Q.28.
    trs_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_qx    (i_quat_x),
        .i_qy    (i_quat_y),
        .i_qz    (i_quat_z),
        .i_qw    (i_quat_w),
        .i_side  (w_side_in),
        .o_valid (w_rot_valid),
        .i_ready (w_rot_ready),
        .o_ent   (w_ent),
        .o_side  (w_side_rot)
    );

    // Column scaling, rounding half up and saturation to Q16.16.
    trs_scl u_scl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rot_valid),
        .o_ready (w_rot_ready),
        .i_ent   (w_ent),
        .i_side  (w_side_rot),
        .o_valid (w_scl_valid),
        .i_ready (w_scl_ready),
        .o_elem  (w_elem),
        .o_side  (w_side_scl)
    );

    // Four column transactions per matrix, the translation column last.
    trs_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_scl_valid),
        .o_ready         (w_scl_ready),
        .i_elem          (w_elem),
        .i_side          (w_side_scl),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_column_index  (o_column_index),
        .o_elem_x        (o_elem_x),
        .o_elem_y        (o_elem_y),
        .o_elem_z        (o_elem_z),
        .o_last_column   (o_last_column),
        .o_last_of_batch (o_last_of_batch)
    );

endmodule

`default_nettype wire

/* sv/trs_chk.sv */
// Port-level checker for the pose-to-matrix composer, bound to the top level.
// Uses the macros of trs_to_instance_matrix_assert.svh and the codes of trs_pkg.
`default_nettype none
`include "trs_to_instance_matrix_assert.svh"

module trs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_column_index,
    input logic signed [31:0] o_elem_x,
    input logic               o_last_column,
    input logic               o_last_of_batch
);

    `TRS_ASSERT_NEXT(a_col_step, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_column, o_out_valid && (o_column_index == $past(o_column_index) + 2'd1), "column transaction not followed by the next column")

    `TRS_ASSERT_NEXT(a_col_restart, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_column, !o_out_valid || (o_column_index == trs_pkg::COL_X), "new matrix does not start at column zero")

    `TRS_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, o_out_valid, o_last_column == (o_column_index == trs_pkg::COL_TRANS), "last column flag disagrees with column index")

    `TRS_ASSERT_NOW(a_batch_flag, i_clk, i_rst_n, o_out_valid && o_last_of_batch, o_last_column, "batch end flagged away from the translation column")

    `TRS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_column_index) && $stable(o_elem_x), "stalled column transaction changed")

endmodule

bind trs_to_instance_matrix trs_chk u_chk (.*);

`default_nettype wire

/* dv/tb_trs_to_instance_matrix.sv */
// Self-checking testbench for the pose-to-matrix composer trs_to_instance_matrix.
// Depends on trs_pkg for the column codes and on the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_trs_to_instance_matrix;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 88;
    // Quiet cycles after the last pose, ample for a column still on its way through.
    localparam int DRAIN_CYCLES     = 20;
    // A limit on the whole run, set well above what the slowest legal run takes.
    localparam int CYCLE_LIMIT      = 200000;

    // One pose as it is presented on the input channel.
    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic               final_instance;
    } t_pose;

    // One matrix column as it leaves the result channel.
    typedef struct {
        logic [1:0]         column_index;
        logic signed [31:0] elem_x;
        logic signed [31:0] elem_y;
        logic signed [31:0] elem_z;
        logic               last_column;
        logic               last_of_batch;
    } t_column;

    // The scoreboard works out the four columns of every accepted pose and holds them,
    // oldest first, until the block delivers the matching column transactions.
    class t_column_scoreboard;
        t_column expected_columns[$];
        int      mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // A Q.28 rotation entry times a raw Q8.8 scale, rounded half up to Q16.16 and
        // clamped to the signed 32-bit range.
        static function logic signed [31:0] scaled_q16(input longint entry, input longint scale);
            longint acc;
            acc = entry * scale + (longint'(1) <<< 19);
            acc = acc >>> 20;
            if (acc > longint'(32'sh7FFF_FFFF)) begin
                acc = longint'(32'sh7FFF_FFFF);
            end
            if (acc < longint'(32'sh8000_0000)) begin
                acc = longint'(32'sh8000_0000);
            end
            return 32'(acc);
        endfunction

        // Forms the rotation matrix from the quaternion as given, with no normalising,
        // and queues the three scaled rotation columns followed by the translation column.
        function void note_pose(input t_pose p);
            longint  qx, qy, qz, qw, sx, sy, sz, one_q28;
            longint  xx, xy, xz, yy, yz, zz, wx, wy, wz;
            t_column c;
            qx = p.quat_x;
            qy = p.quat_y;
            qz = p.quat_z;
            qw = p.quat_w;
            sx = p.scale_x;
            sy = p.scale_y;
            sz = p.scale_z;
            one_q28 = longint'(1) <<< 28;
            xx = 2 * qx * qx;
            xy = 2 * qx * qy;
            xz = 2 * qx * qz;
            yy = 2 * qy * qy;
            yz = 2 * qy * qz;
            zz = 2 * qz * qz;
            wx = 2 * qw * qx;
            wy = 2 * qw * qy;
            wz = 2 * qw * qz;

            c.last_column   = 1'b0;
            c.last_of_batch = 1'b0;

            c.column_index = trs_pkg::COL_X;
            c.elem_x = scaled_q16(one_q28 - (yy + zz), sx);
            c.elem_y = scaled_q16(xy + wz, sx);
            c.elem_z = scaled_q16(xz - wy, sx);
            expected_columns.push_back(c);

            c.column_index = trs_pkg::COL_Y;
            c.elem_x = scaled_q16(xy - wz, sy);
            c.elem_y = scaled_q16(one_q28 - (xx + zz), sy);
            c.elem_z = scaled_q16(yz + wx, sy);
            expected_columns.push_back(c);

            c.column_index = trs_pkg::COL_Z;
            c.elem_x = scaled_q16(xz + wy, sz);
            c.elem_y = scaled_q16(yz - wx, sz);
            c.elem_z = scaled_q16(one_q28 - (xx + yy), sz);
            expected_columns.push_back(c);

            // The translation column passes the position straight through and closes
            // the instance; only here does the batch flag show.
            c.column_index  = trs_pkg::COL_TRANS;
            c.elem_x        = p.pos_x;
            c.elem_y        = p.pos_y;
            c.elem_z        = p.pos_z;
            c.last_column   = 1'b1;
            c.last_of_batch = p.final_instance;
            expected_columns.push_back(c);
        endfunction

        task check_column(input t_column got);
            t_column want;
            if (expected_columns.size() == 0) begin
                report_mismatch($sformatf("column %0d arrived with nothing expected",
                                          got.column_index));
            end else begin
                want = expected_columns.pop_front();
                if (got.column_index !== want.column_index) begin
                    report_mismatch($sformatf("column_index: expected %0d, got %0d",
                                              want.column_index, got.column_index));
                end
                if (got.elem_x !== want.elem_x) begin
                    report_mismatch($sformatf("column %0d elem_x: expected %h, got %h",
                                              want.column_index, want.elem_x, got.elem_x));
                end
                if (got.elem_y !== want.elem_y) begin
                    report_mismatch($sformatf("column %0d elem_y: expected %h, got %h",
                                              want.column_index, want.elem_y, got.elem_y));
                end
                if (got.elem_z !== want.elem_z) begin
                    report_mismatch($sformatf("column %0d elem_z: expected %h, got %h",
                                              want.column_index, want.elem_z, got.elem_z));
                end
                if (got.last_column !== want.last_column) begin
                    report_mismatch($sformatf("column %0d last_column: expected %b, got %b",
                                              want.column_index, want.last_column,
                                              got.last_column));
                end
                if (got.last_of_batch !== want.last_of_batch) begin
                    report_mismatch($sformatf("column %0d last_of_batch: expected %b, got %b",
                                              want.column_index, want.last_of_batch,
                                              got.last_of_batch));
                end
            end
        endtask

        function int pending();
            return expected_columns.size();
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic signed [31:0] i_pos_x          = '0;
    logic signed [31:0] i_pos_y          = '0;
    logic signed [31:0] i_pos_z          = '0;
    logic signed [15:0] i_quat_x         = '0;
    logic signed [15:0] i_quat_y         = '0;
    logic signed [15:0] i_quat_z         = '0;
    logic signed [15:0] i_quat_w         = '0;
    logic signed [15:0] i_scale_x        = '0;
    logic signed [15:0] i_scale_y        = '0;
    logic signed [15:0] i_scale_z        = '0;
    logic               i_final_instance = 1'b0;
    logic               i_out_ready      = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_column_index;
    logic signed [31:0] o_elem_x;
    logic signed [31:0] o_elem_y;
    logic signed [31:0] o_elem_z;
    logic               o_last_column;
    logic               o_last_of_batch;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    t_column_scoreboard sb = new();

    trs_to_instance_matrix dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_quat_x         (i_quat_x),
        .i_quat_y         (i_quat_y),
        .i_quat_z         (i_quat_z),
        .i_quat_w         (i_quat_w),
        .i_scale_x        (i_scale_x),
        .i_scale_y        (i_scale_y),
        .i_scale_z        (i_scale_z),
        .i_final_instance (i_final_instance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_column_index   (o_column_index),
        .o_elem_x         (o_elem_x),
        .o_elem_y         (o_elem_y),
        .o_elem_z         (o_elem_z),
        .o_last_column    (o_last_column),
        .o_last_of_batch  (o_last_of_batch)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Watchdog: a hang or a lost column ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side. Outputs are read at the rising edge before any flop of the block
    // has updated, so the values seen are the ones the handshake closed on. Ready is
    // then redrawn once per cycle, which spreads stalls over every column position.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_column(t_column'{o_column_index, o_elem_x, o_elem_y, o_elem_z,
                                      o_last_column, o_last_of_batch});
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic t_pose mk_pose(input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] pz, input logic [15:0] qx,
                                      input logic [15:0] qy, input logic [15:0] qz,
                                      input logic [15:0] qw, input logic [15:0] sx,
                                      input logic [15:0] sy, input logic [15:0] sz,
                                      input logic fin);
        t_pose p;
        p.pos_x          = px;
        p.pos_y          = py;
        p.pos_z          = pz;
        p.quat_x         = qx;
        p.quat_y         = qy;
        p.quat_z         = qz;
        p.quat_w         = qw;
        p.scale_x        = sx;
        p.scale_y        = sy;
        p.scale_z        = sz;
        p.final_instance = fin;
        return p;
    endfunction

    function automatic logic [15:0] corner16();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] corner32();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random poses: plenty of fully random ones for bit toggling and large products,
    // unnormalised quaternions with components up to one and modest scales for the everyday
    // range, corner values, and single-axis quaternions. About one pose in eight closes a batch.
    function automatic t_pose random_pose();
        t_pose p;
        int    kind;
        kind = $urandom_range(0, 9);
        p = mk_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), ($urandom_range(0, 7) == 0));
        if (kind >= 4 && kind <= 6) begin
            p.quat_x  = 16'($urandom_range(0, 32768) - 16384);
            p.quat_y  = 16'($urandom_range(0, 32768) - 16384);
            p.quat_z  = 16'($urandom_range(0, 32768) - 16384);
            p.quat_w  = 16'($urandom_range(0, 32768) - 16384);
            p.scale_x = 16'($urandom_range(0, 2048) - 1024);
            p.scale_y = 16'($urandom_range(0, 2048) - 1024);
            p.scale_z = 16'($urandom_range(0, 2048) - 1024);
        end else if (kind >= 7 && kind <= 8) begin
            p.pos_x   = corner32();
            p.pos_y   = corner32();
            p.pos_z   = corner32();
            p.quat_x  = corner16();
            p.quat_y  = corner16();
            p.quat_z  = corner16();
            p.quat_w  = corner16();
            p.scale_x = corner16();
            p.scale_y = corner16();
            p.scale_z = corner16();
        end else if (kind == 9) begin
            p.quat_x = '0;
            p.quat_y = '0;
            p.quat_z = '0;
            case ($urandom_range(0, 2))
                0:       p.quat_x = 16'($urandom);
                1:       p.quat_y = 16'($urandom);
                default: p.quat_z = 16'($urandom);
            endcase
        end
        return p;
    endfunction

    // Presents one pose transaction and returns at the edge that accepted it. Valid is
    // raised only after any idle cycles and is not dropped until acceptance; a caller
    // that follows up in the same time step makes the only assignment to valid there.
    task automatic send_pose(input t_pose p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_pos_x          <= p.pos_x;
        i_pos_y          <= p.pos_y;
        i_pos_z          <= p.pos_z;
        i_quat_x         <= p.quat_x;
        i_quat_y         <= p.quat_y;
        i_quat_z         <= p.quat_z;
        i_quat_w         <= p.quat_w;
        i_scale_x        <= p.scale_x;
        i_scale_y        <= p.scale_y;
        i_scale_z        <= p.scale_z;
        i_final_instance <= p.final_instance;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_pose(p);
    endtask

    // Holds the sender back until every expected column has been delivered, so the
    // block runs fully empty and then restarts from an idle pipeline.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with neither side idling.
        // Identity rotation with unit scales and the origin.
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000, 16'h4000,
                          16'h0100, 16'h0100, 16'h0100, 1'b0));
        // Position extremes pass through the translation column, with the batch end.
        send_pose(mk_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'h0000, 16'h0000,
                          16'h0000, 16'h4000, 16'h0100, 16'h0100, 16'h0100, 1'b1));
        send_pose(mk_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
                          16'h0000, 16'h4000, 16'h0100, 16'h0100, 16'h0100, 1'b0));
        // Non-unit quaternions at the field limits, driving entries to their largest magnitudes.
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 1'b1));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h8000, 16'h8000, 16'h8000, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000, 16'h4000,
                          16'h0100, 16'h0100, 16'h0100, 1'b0));
        // Zero quaternion: only the diagonal ones survive, and zero scales clear them.
        send_pose(mk_pose(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
        // A quarter turn about z with mixed scales, one of them a mirror.
        send_pose(mk_pose(32'h0010_0000, 32'hFFF0_0000, 32'h0, 16'h0000, 16'h0000,
                          16'h2D41, 16'h2D41, 16'h0100, 16'h0200, 16'hFF00, 1'b0));
        // Exact rounding ties: 32 in Q.28 times 2^14 lands on half an LSB, which rounds
        // up for the positive product and to zero for the negative one.
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0004, 16'h0004, 16'h0000, 16'h0000,
                          16'h4000, 16'h4000, 16'h4000, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0004, 16'h0004, 16'h0000, 16'h0000,
                          16'hC000, 16'hC000, 16'hC000, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0004, 16'h0004,
                          16'h4000, 16'h4000, 16'h4000, 1'b0));
        // Negative w, negative unit scales, the smallest non-zero components.
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000, 16'hC000,
                          16'h0100, 16'h0100, 16'h0100, 1'b1));
        send_pose(mk_pose(32'h1234_5678, 32'h0, 32'h0, 16'h1000, 16'hF000, 16'h0800,
                          16'h3000, 16'hFF00, 16'hFF00, 16'hFF00, 1'b0));
        send_pose(mk_pose(32'h0, 32'h0, 32'h0, 16'h0001, 16'h0001, 16'h0001, 16'h0001,
                          16'h0001, 16'h0001, 16'h0001, 1'b0));
        // Alternating bit patterns, both phases.
        send_pose(mk_pose(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555,
                          16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 1'b1));
        send_pose(mk_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA,
                          16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
        drain_results();

        // Random part in four idling phases; each ends with the pipeline emptied.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            repeat (RANDOM_PER_PHASE) send_pose(random_pose());
            drain_results();
        end

        // Quiet cycles catch any column that turns up after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
